>>> design/bfg_pkg.sv
package bfg_pkg;

  localparam int FIELD_W      = 16;
  localparam int LEN_BITS_DEF = 16;
  localparam int AXIS_W       = 2;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

endpackage

>>> design/bfg_ifs.sv
interface bfg_req_if import bfg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] box_len_a;
  logic [FIELD_W-1:0] box_len_b;
  logic [FIELD_W-1:0] box_len_c;
  logic [FIELD_W-1:0] part_len_a;
  logic [FIELD_W-1:0] part_len_b;
  logic [FIELD_W-1:0] part_len_c;

  modport source (
    output valid, box_len_a, box_len_b, box_len_c, part_len_a, part_len_b, part_len_c,
    input  ready
  );
  modport sink (
    input  valid, box_len_a, box_len_b, box_len_c, part_len_a, part_len_b, part_len_c,
    output ready
  );
endinterface

interface bfg_res_if import bfg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               fits;
  logic               sub_valid;
  logic [AXIS_W-1:0]  cut_axis;
  logic [FIELD_W-1:0] sub_width;
  logic [FIELD_W-1:0] sub_height;
  logic [FIELD_W-1:0] sub_length;
  logic               last_of_run;

  modport source (
    output valid, fits, sub_valid, cut_axis, sub_width, sub_height, sub_length,
           last_of_run,
    input  ready
  );
  modport sink (
    input  valid, fits, sub_valid, cut_axis, sub_width, sub_height, sub_length,
           last_of_run,
    output ready
  );
endinterface

>>> design/bfg_sort3.sv
module bfg_sort3 import bfg_pkg::*; #(
  parameter int W = LEN_BITS_DEF
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] c_i,
  output logic [W-1:0] hi_o,
  output logic [W-1:0] mid_o,
  output logic [W-1:0] lo_o
);

  logic [W-1:0] x0, x1, y0, y2, z1, z2;

  always_comb begin
    x0 = (a_i < b_i) ? b_i : a_i;
    x1 = (a_i < b_i) ? a_i : b_i;
    y0 = (x0 < c_i) ? c_i : x0;
    y2 = (x0 < c_i) ? x0 : c_i;
    z1 = (x1 < y2) ? y2 : x1;
    z2 = (x1 < y2) ? x1 : y2;
  end

  assign hi_o  = y0;
  assign mid_o = z1;
  assign lo_o  = z2;

endmodule

>>> design/box_fit_guillotine_split_unit.sv
// Guillotine split unit: each request carries a free box and an item, both as three side
// lengths. The unit sorts both triples, checks the fit and, on a fit, returns the leftover
// sub-boxes along x, y and z (a sub-box with zero leftover on its own axis is dropped).
// A request gives one to three results, one per cycle while res_o.ready is high, with
// last_of_run on the final one; a miss or a fit without leftover gives a single result
// with sub_valid low. The pipeline has three register stages (sort, fit and leftover,
// cut choice into the output hold stage). The single result channel sets the rate: a
// request holds the output hold stage until its last result is taken, while the stages
// ahead of it keep accepting requests until they fill.
module box_fit_guillotine_split_unit import bfg_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  bfg_req_if.sink  req_i,
  bfg_res_if.source res_o
);

  // Sort stage.
  logic [LEN_BITS-1:0] bs_hi, bs_mid, bs_lo, ps_hi, ps_mid, ps_lo;
  logic                v1_q;
  logic [LEN_BITS-1:0] b1_q [3];
  logic [LEN_BITS-1:0] p1_q [3];

  // Fit and leftover stage.
  logic                v2_q, fit2_q;
  logic [LEN_BITS-1:0] b2_q [3];
  logic [LEN_BITS-1:0] p2_q [3];
  logic [LEN_BITS-1:0] lf2_q [3];
  logic                fit_d;

  // Output hold stage.
  logic                hv_q, fit_q;
  logic [2:0]          pend_q, pend_d, keep_d, low_bit;
  logic [LEN_BITS-1:0] ext_q [3][3];
  logic [LEN_BITS-1:0] ext_d [3][3];
  logic [5:0]          sel;

  logic hold_take, r1, r2, last_res;
  axis_e axis;

  bfg_sort3 #(.W(LEN_BITS)) u_sort_box (
    .a_i  (LEN_BITS'(req_i.box_len_a)),
    .b_i  (LEN_BITS'(req_i.box_len_b)),
    .c_i  (LEN_BITS'(req_i.box_len_c)),
    .hi_o (bs_hi),
    .mid_o(bs_mid),
    .lo_o (bs_lo)
  );

  bfg_sort3 #(.W(LEN_BITS)) u_sort_part (
    .a_i  (LEN_BITS'(req_i.part_len_a)),
    .b_i  (LEN_BITS'(req_i.part_len_b)),
    .c_i  (LEN_BITS'(req_i.part_len_c)),
    .hi_o (ps_hi),
    .mid_o(ps_mid),
    .lo_o (ps_lo)
  );

  assign low_bit   = pend_q & (~pend_q + 3'd1);
  assign last_res  = ((pend_q & (pend_q - 3'd1)) == 3'd0);
  assign hold_take = !hv_q || (res_o.ready && last_res);
  assign r2        = !v2_q || hold_take;
  assign r1        = !v1_q || r2;
  assign req_i.ready = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      hv_q <= 1'b0;
      pend_q <= 3'b000;
    end else begin
      if (r1) v1_q <= req_i.valid;
      if (r2) v2_q <= v1_q;
      if (hold_take) begin
        hv_q <= v2_q;
        pend_q <= pend_d;
      end else if (res_o.ready) begin
        pend_q <= pend_q & ~low_bit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && req_i.valid) begin
      b1_q[0] <= bs_hi;
      b1_q[1] <= bs_mid;
      b1_q[2] <= bs_lo;
      p1_q[0] <= ps_hi;
      p1_q[1] <= ps_mid;
      p1_q[2] <= ps_lo;
    end
    if (r2 && v1_q) begin
      fit2_q <= fit_d;
      b2_q   <= b1_q;
      p2_q   <= p1_q;
      for (int i = 0; i < 3; i++) lf2_q[i] <= b1_q[i] - p1_q[i];
    end
    if (hold_take && v2_q) begin
      fit_q <= fit2_q;
      ext_q <= ext_d;
    end
  end

  assign fit_d = (p1_q[0] <= b1_q[0]) && (p1_q[1] <= b1_q[1]) && (p1_q[2] <= b1_q[2]);

  // Cut choice. Select bits, high to low: x.height, x.length, y.width, y.length,
  // z.width, z.height; a one takes the box side, a zero the item side.
  always_comb begin
    logic [LEN_BITS-1:0] w, h, l;
    w = lf2_q[0];
    h = lf2_q[1];
    l = lf2_q[2];
    if (l >= w && w >= h)      sel = 6'b011100;
    else if (l >= h && h >= w) sel = 6'b110100;
    else if (w >= h && h >= l) sel = 6'b001011;
    else if (w >= l && l >= h) sel = 6'b001110;
    else if (h >= w && w >= l) sel = 6'b100011;
    else                       sel = 6'b110001;

    ext_d[0][0] = w;
    ext_d[0][1] = sel[5] ? b2_q[1] : p2_q[1];
    ext_d[0][2] = sel[4] ? b2_q[2] : p2_q[2];
    ext_d[1][0] = sel[3] ? b2_q[0] : p2_q[0];
    ext_d[1][1] = h;
    ext_d[1][2] = sel[2] ? b2_q[2] : p2_q[2];
    ext_d[2][0] = sel[1] ? b2_q[0] : p2_q[0];
    ext_d[2][1] = sel[0] ? b2_q[1] : p2_q[1];
    ext_d[2][2] = l;

    keep_d = {l != '0, h != '0, w != '0};
    pend_d = (v2_q && fit2_q) ? keep_d : 3'b000;
  end

  always_comb begin
    if (pend_q[0])      axis = AXIS_X;
    else if (pend_q[1]) axis = AXIS_Y;
    else                axis = AXIS_Z;
  end

  assign res_o.valid       = hv_q;
  assign res_o.fits        = fit_q;
  assign res_o.sub_valid   = (pend_q != 3'b000);
  assign res_o.last_of_run = last_res;

  always_comb begin
    if (pend_q == 3'b000) begin
      res_o.cut_axis   = AXIS_X;
      res_o.sub_width  = '0;
      res_o.sub_height = '0;
      res_o.sub_length = '0;
    end else begin
      res_o.cut_axis   = axis;
      res_o.sub_width  = FIELD_W'(ext_q[axis][0]);
      res_o.sub_height = FIELD_W'(ext_q[axis][1]);
      res_o.sub_length = FIELD_W'(ext_q[axis][2]);
    end
  end

endmodule

>>> dv/bfg_split_checker.sv
module bfg_split_checker import bfg_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  bfg_req_if   req_i,
  bfg_res_if   res_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   req_count_o,
  output int   res_count_o,
  output int   miss_count_o,
  output int   exact_count_o
);

  typedef logic [LEN_BITS-1:0] len_t;
  typedef logic [2:0][LEN_BITS-1:0] side3_t;

  typedef struct packed {
    logic               fits;
    logic               sub_valid;
    axis_e              cut_axis;
    logic [FIELD_W-1:0] sub_width;
    logic [FIELD_W-1:0] sub_height;
    logic [FIELD_W-1:0] sub_length;
    logic               last_of_run;
  } split_res_t;

  localparam axis_e AXIS_OF [3] = '{AXIS_X, AXIS_Y, AXIS_Z};

  split_res_t split_q [$];
  int fails = 0;
  int reqs = 0;
  int results = 0;
  int misses = 0;
  int exacts = 0;

  function automatic side3_t sort_desc(side3_t v);
    len_t t;
    if (v[0] < v[1]) begin
      t = v[0]; v[0] = v[1]; v[1] = t;
    end
    if (v[0] < v[2]) begin
      t = v[0]; v[0] = v[2]; v[2] = t;
    end
    if (v[1] < v[2]) begin
      t = v[1]; v[1] = v[2]; v[2] = t;
    end
    return v;
  endfunction

  function automatic string describe_split(split_res_t r);
    return $sformatf("fits=%0b sub_valid=%0b axis=%0d w=%0d h=%0d l=%0d last=%0b",
                     r.fits, r.sub_valid, r.cut_axis, r.sub_width, r.sub_height,
                     r.sub_length, r.last_of_run);
  endfunction

  // Works out the results of one request and appends them to the split queue.
  task automatic predict_split(input side3_t box_in, input side3_t part_in);
    side3_t bx, pt, lft;
    logic [2:0][2:0][LEN_BITS-1:0] ext;
    len_t wl, hl, ll;
    split_res_t r;
    int last_axis;
    bx = sort_desc(box_in);
    pt = sort_desc(part_in);
    r = '0;
    r.cut_axis = AXIS_X;
    r.last_of_run = 1'b1;
    if (pt[0] > bx[0] || pt[1] > bx[1] || pt[2] > bx[2]) begin
      misses++;
      split_q.insert(split_q.size(), r);
    end else begin
      ext = '0;
      for (int a = 0; a < 3; a++) begin
        lft[a] = bx[a] - pt[a];
        ext[a][a] = lft[a];
      end
      wl = lft[0];
      hl = lft[1];
      ll = lft[2];
      if (ll >= wl && wl >= hl) begin
        ext[0][1] = pt[1]; ext[0][2] = bx[2];
        ext[1][0] = bx[0]; ext[1][2] = bx[2];
        ext[2][0] = pt[0]; ext[2][1] = pt[1];
      end else if (ll >= hl && hl >= wl) begin
        ext[0][1] = bx[1]; ext[0][2] = bx[2];
        ext[1][0] = pt[0]; ext[1][2] = bx[2];
        ext[2][0] = pt[0]; ext[2][1] = pt[1];
      end else if (wl >= hl && hl >= ll) begin
        ext[0][1] = pt[1]; ext[0][2] = pt[2];
        ext[1][0] = bx[0]; ext[1][2] = pt[2];
        ext[2][0] = bx[0]; ext[2][1] = bx[1];
      end else if (wl >= ll && ll >= hl) begin
        ext[0][1] = pt[1]; ext[0][2] = pt[2];
        ext[1][0] = bx[0]; ext[1][2] = bx[2];
        ext[2][0] = bx[0]; ext[2][1] = pt[1];
      end else if (hl >= wl && wl >= ll) begin
        ext[0][1] = bx[1]; ext[0][2] = pt[2];
        ext[1][0] = pt[0]; ext[1][2] = pt[2];
        ext[2][0] = bx[0]; ext[2][1] = bx[1];
      end else begin
        ext[0][1] = bx[1]; ext[0][2] = bx[2];
        ext[1][0] = pt[0]; ext[1][2] = pt[2];
        ext[2][0] = pt[0]; ext[2][1] = bx[1];
      end
      last_axis = -1;
      for (int a = 0; a < 3; a++) begin
        if (lft[a] != 0) last_axis = a;
      end
      r.fits = 1'b1;
      if (last_axis < 0) begin
        exacts++;
        split_q.insert(split_q.size(), r);
      end else begin
        for (int a = 0; a < 3; a++) begin
          if (lft[a] != 0) begin
            r.sub_valid = 1'b1;
            r.cut_axis = AXIS_OF[a];
            r.sub_width = FIELD_W'(ext[a][0]);
            r.sub_height = FIELD_W'(ext[a][1]);
            r.sub_length = FIELD_W'(ext[a][2]);
            r.last_of_run = (a == last_axis);
            split_q.insert(split_q.size(), r);
          end
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    side3_t box_in, part_in;
    split_res_t seen, want;
    if (rst_ni) begin
      if (res_i.valid && res_i.ready) begin
        seen.fits = res_i.fits;
        seen.sub_valid = res_i.sub_valid;
        seen.cut_axis = axis_e'(res_i.cut_axis);
        seen.sub_width = res_i.sub_width;
        seen.sub_height = res_i.sub_height;
        seen.sub_length = res_i.sub_length;
        seen.last_of_run = res_i.last_of_run;
        results++;
        if (split_q.size() == 0) begin
          fails++;
          $display("%0t: result with no request waiting: %s", $time, describe_split(seen));
        end else begin
          want = split_q.pop_front();
          if (seen !== want) begin
            fails++;
            $display("%0t: result mismatch\n  expected %s\n  actual   %s", $time,
                     describe_split(want), describe_split(seen));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        box_in[0] = len_t'(req_i.box_len_a);
        box_in[1] = len_t'(req_i.box_len_b);
        box_in[2] = len_t'(req_i.box_len_c);
        part_in[0] = len_t'(req_i.part_len_a);
        part_in[1] = len_t'(req_i.part_len_b);
        part_in[2] = len_t'(req_i.part_len_c);
        reqs++;
        predict_split(box_in, part_in);
      end
    end
    fail_count_o <= fails;
    pending_o <= split_q.size();
    req_count_o <= reqs;
    res_count_o <= results;
    miss_count_o <= misses;
    exact_count_o <= exacts;
  end

endmodule

>>> dv/tb_box_fit_guillotine_split_unit.sv
module tb_box_fit_guillotine_split_unit;
  import bfg_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PER_PHASE = 130;
  localparam int PERM [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                 '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

  typedef logic [FIELD_W-1:0] len_t;

  logic clk_i;
  logic rst_ni;
  int send_idle = 7;
  int recv_idle = 56;
  int stall_cycles = 0;
  int fail_count, pending, req_count, res_count, miss_count, exact_count;

  bfg_req_if req_if ();
  bfg_res_if res_if ();

  box_fit_guillotine_split_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  bfg_split_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .res_i         (res_if),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .req_count_o   (req_count),
    .res_count_o   (res_count),
    .miss_count_o  (miss_count),
    .exact_count_o (exact_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL box_fit_guillotine_split_unit");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic send_request(input len_t box_a, input len_t box_b, input len_t box_c,
                              input len_t part_a, input len_t part_b, input len_t part_c);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.box_len_a <= box_a;
    req_if.box_len_b <= box_b;
    req_if.box_len_c <= box_c;
    req_if.part_len_a <= part_a;
    req_if.part_len_b <= part_b;
    req_if.part_len_c <= part_c;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Most requests are built to fit, so that the cut choice and the dropped
  // sub-boxes are reached often; the rest are tiny or fully random sides.
  task automatic send_random();
    len_t bx [3];
    len_t pt [3];
    int mode, pb, pp;
    mode = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (mode < 20) begin
        bx[i] = len_t'($urandom_range(7));
        pt[i] = len_t'($urandom_range(7));
      end else if (mode < 45) begin
        bx[i] = len_t'($urandom);
        pt[i] = len_t'($urandom);
      end else begin
        bx[i] = len_t'($urandom);
        case ($urandom_range(3))
          0: pt[i] = bx[i];
          1: pt[i] = (bx[i] > 4) ? bx[i] - len_t'($urandom_range(4, 1)) : bx[i];
          default: pt[i] = len_t'($urandom_range(bx[i]));
        endcase
      end
    end
    pb = $urandom_range(5);
    pp = $urandom_range(5);
    send_request(bx[PERM[pb][0]], bx[PERM[pb][1]], bx[PERM[pb][2]],
                 pt[PERM[pp][0]], pt[PERM[pp][1]], pt[PERM[pp][2]]);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.box_len_a = '0;
    req_if.box_len_b = '0;
    req_if.box_len_c = '0;
    req_if.part_len_a = '0;
    req_if.part_len_b = '0;
    req_if.part_len_c = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes: empty box, full box, oversized item.
    send_request(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    send_request(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_request(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    // Misses on the largest and on the smallest sorted side.
    send_request(16'd10, 16'd20, 16'd30, 16'd31, 16'd5, 16'd5);
    send_request(16'd30, 16'd20, 16'd10, 16'd29, 16'd19, 16'd11);
    // The six cut orders, with the sides given in scrambled order.
    send_request(16'd100, 16'd200, 16'd150, 16'd70, 16'd180, 16'd140);
    send_request(16'd150, 16'd100, 16'd200, 16'd190, 16'd70, 16'd130);
    send_request(16'd200, 16'd150, 16'd100, 16'd130, 16'd90, 16'd170);
    send_request(16'd100, 16'd150, 16'd200, 16'd170, 16'd140, 16'd80);
    send_request(16'd200, 16'd100, 16'd150, 16'd90, 16'd180, 16'd120);
    send_request(16'd150, 16'd200, 16'd100, 16'd120, 16'd80, 16'd190);
    // Zero leftovers on one or two axes, equal leftovers, and equal sides.
    send_request(16'd200, 16'd150, 16'd100, 16'd200, 16'd130, 16'd70);
    send_request(16'd200, 16'd150, 16'd100, 16'd180, 16'd150, 16'd70);
    send_request(16'd200, 16'd150, 16'd100, 16'd180, 16'd130, 16'd100);
    send_request(16'd200, 16'd150, 16'd100, 16'd200, 16'd150, 16'd70);
    send_request(16'd200, 16'd150, 16'd100, 16'd200, 16'd130, 16'd100);
    send_request(16'd200, 16'd150, 16'd100, 16'd180, 16'd150, 16'd100);
    send_request(16'd200, 16'd150, 16'd100, 16'd190, 16'd140, 16'd90);
    send_request(16'd5, 16'd5, 16'd5, 16'd5, 16'd4, 16'd5);
    wait_drained();

    repeat (RANDOM_PER_PHASE) send_random();
    wait_drained();
    send_idle = 56;
    recv_idle = 7;
    repeat (RANDOM_PER_PHASE) send_random();
    wait_drained();
    send_idle = 0;
    recv_idle = 0;
    repeat (RANDOM_PER_PHASE) send_random();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests under three idle mixes and checked %0d results.",
             req_count, res_count);
    $display("Among them %0d misses and %0d exact fits; the rest split into sub-boxes.",
             miss_count, exact_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS box_fit_guillotine_split_unit");
    end else begin
      $display("%0d mismatches, %0d results still expected", fail_count, pending);
      $display("FAIL box_fit_guillotine_split_unit");
    end
    $finish;
  end

endmodule
